@@ hdl/rv32_exu_pkg.sv @@
// Shared types, opcodes and codes for the RV32 subset execute unit.
package rv32_exu_pkg;

  typedef struct packed {
    logic        command;
    logic [31:0] instruction;
    logic [31:0] read_data;
  } exu_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  bus_op;
    logic [31:0] bus_address;
    logic [31:0] bus_write_data;
    logic [31:0] next_pc;
    logic [4:0]  writeback_index;
    logic [31:0] writeback_value;
  } exu_out_t;

  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_AMO    = 7'h2F;

  localparam logic [2:0] ST_RETIRED  = 3'd0;
  localparam logic [2:0] ST_AWAIT    = 3'd1;
  localparam logic [2:0] ST_ILLEGAL  = 3'd2;
  localparam logic [2:0] ST_NOEXT    = 3'd3;
  localparam logic [2:0] ST_HALTED   = 3'd4;
  localparam logic [2:0] ST_UNEXPECT = 3'd5;

  localparam logic [2:0] BUS_NONE = 3'd0;
  localparam logic [2:0] BUS_RDBS = 3'd1;
  localparam logic [2:0] BUS_RDBU = 3'd2;
  localparam logic [2:0] BUS_RDW  = 3'd3;
  localparam logic [2:0] BUS_WRB  = 3'd4;
  localparam logic [2:0] BUS_WRW  = 3'd5;

  localparam logic [2:0] PK_NONE  = 3'd0;
  localparam logic [2:0] PK_LB    = 3'd1;
  localparam logic [2:0] PK_LBU   = 3'd2;
  localparam logic [2:0] PK_LW    = 3'd3;
  localparam logic [2:0] PK_AMOADD = 3'd4;
  localparam logic [2:0] PK_AMOOR = 3'd5;

  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_MULDIV   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic rf_read;    // register operands into the operand registers
    logic exec;       // evaluate and capture the result
    logic div_start;  // load the divider
    logic div_step;   // one restoring step
    logic div_done;   // write the quotient result
  } exu_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_div;
    logic div_last;
  } exu_sts_t;

endpackage

@@ hdl/rv32i_subset_execute_unit.sv @@
// Top level of the RV32 subset execute unit.
//
// Usage: items arrive on in_valid_i/in_ready_o carrying in_data_i (command,
// instruction, read_data). Each accepted item yields exactly one result on
// out_valid_o/out_ready_i as out_data_o. Configuration (start_pc at index
// 0, mul_div_enable at index 1) is written on cfg_valid_i/cfg_ready_o while
// the block is idle; writing start_pc also loads the program counter.
// Most items pass the read and execute states before the result is
// loaded into the output register; DIV runs a restoring divider one
// quotient bit per cycle in between. One item is in work at a time; the
// next transfer in is taken the cycle after the result is loaded into the
// output register.
// Reset clears the register file (through per-entry valid bits), pending
// read state and the halt flag, loads the pc with 0 and enables MUL/DIV.
// When the receiver stalls the result holds in the output register and a
// finished item waits in the datapath until the register frees.
// After an illegal or disabled-extension instruction every item answers
// halted until reset.
module rv32i_subset_execute_unit import rv32_exu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  exu_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output exu_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  exu_cmd_t cmd;
  exu_sts_t sts;
  exu_out_t result;
  logic     out_load, busy;
  logic     out_valid_q;
  exu_out_t out_q;

  assign cfg_ready_o = !busy;

  rv32_exu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_i (out_valid_q),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .out_load_o  (out_load),
    .busy_o      (busy)
  );

  rv32_exu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_take_i   (in_valid_i && in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result)
  );

  // Hold the result until its transfer out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/rv32_exu_ctrl.sv @@
// Sequencing controller for the RV32 subset execute unit.
module rv32_exu_ctrl import rv32_exu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  exu_sts_t sts_i,
  output exu_cmd_t cmd_o,
  output logic     out_load_o,
  output logic     busy_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DFIN = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_free;

  // Output register can be refilled when empty or being drained
  assign out_free = !out_valid_i || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.rf_read = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DFIN;
      end
      S_DFIN: begin
        if (out_free) begin
          cmd_o.div_done = 1'b1;
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/rv32_exu_dp.sv @@
// Datapath of the RV32 subset execute unit: registers, ALU, divider, state.
module rv32_exu_dp import rv32_exu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  exu_cmd_t    cmd_i,
  output exu_sts_t    sts_o,
  input  logic        in_take_i,
  input  exu_in_t     in_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output exu_out_t    result_o
);

  logic [31:0] rf_q [32];
  logic [31:0] rf_valid_q;
  logic [31:0] pc_q;
  logic        md_en_q;
  logic [2:0]  pk_q;
  logic [4:0]  pd_q;
  logic [31:0] pa_q, po_q;
  logic        halt_q;
  exu_in_t     it_q;
  logic [31:0] a_q, b_q;

  // Divider state
  logic [31:0] dq_q, drem_q, dmag_q;
  logic [4:0]  dcnt_q;
  logic        dneg_q, dzero_q, dovf_q;
  logic [31:0] dvnd_q;
  logic [31:0] dsh_q;
  logic        dvnd_mag_bit;
  logic [32:0] dtrial;

  logic [31:0] w;
  logic [6:0]  opc;
  logic [4:0]  dst;
  logic [2:0]  f3;
  logic [6:0]  f7;
  assign w   = it_q.instruction;
  assign opc = w[6:0];
  assign dst = w[11:7];
  assign f3  = w[14:12];
  assign f7  = w[31:25];

  logic [31:0] iimm, simm, bimm, jimm;
  assign iimm = {{20{w[31]}}, w[31:20]};
  assign simm = {{20{w[31]}}, w[31:25], w[11:7]};
  assign bimm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign jimm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

  logic is_div;
  assign is_div = !it_q.command && !halt_q && pk_q == PK_NONE && opc == OPC_OP
                  && f7[0] && f3 == 3'd4 && md_en_q;
  assign sts_o.is_div   = is_div;
  assign sts_o.div_last = (dcnt_q == 5'd31);

  // Multiplier product, one 32x32 unit
  logic [63:0] prod;
  assign prod = {32'd0, a_q} * {32'd0, b_q};

  // Evaluate one item
  exu_out_t   r;
  logic       r_halt, r_pcw;
  logic [31:0] r_pc;
  logic [2:0]  r_pk;
  logic [31:0] r_pa, r_po;
  logic [4:0]  r_pd;
  logic [31:0] got, wbv;
  logic        wbe, take;
  logic [2:0]  h_st;

  always_comb begin
    r = '0;
    r.next_pc = pc_q;
    r_halt = 1'b0;
    r_pcw = 1'b0;
    r_pc = pc_q + 32'd4;
    r_pk = pk_q;
    r_pa = pa_q;
    r_po = po_q;
    r_pd = pd_q;
    got = '0;
    wbv = '0;
    wbe = 1'b0;
    take = 1'b0;
    h_st = '0;
    if (halt_q) begin
      r.status = ST_HALTED;
    end else if (it_q.command) begin
      if (pk_q == PK_NONE) begin
        r.status = ST_UNEXPECT;
      end else begin
        case (pk_q)
          PK_LB:   got = {{24{it_q.read_data[7]}}, it_q.read_data[7:0]};
          PK_LBU:  got = {24'd0, it_q.read_data[7:0]};
          default: got = it_q.read_data;
        endcase
        if (pk_q == PK_AMOADD || pk_q == PK_AMOOR) begin
          r.bus_op = BUS_WRW;
          r.bus_address = pa_q;
          r.bus_write_data = (pk_q == PK_AMOADD) ? it_q.read_data + po_q
                                                 : it_q.read_data | po_q;
        end
        wbe = 1'b1;
        wbv = got;
        r_pk = PK_NONE;
        r.status = ST_RETIRED;
      end
    end else if (pk_q != PK_NONE) begin
      r.status = ST_UNEXPECT;
    end else begin
      r.status = ST_RETIRED;
      r_pcw = 1'b1;
      case (opc)
        OPC_AUIPC: begin wbe = 1'b1; wbv = pc_q + {w[31:12], 12'd0}; end
        OPC_LUI:   begin wbe = 1'b1; wbv = {w[31:12], 12'd0}; end
        OPC_JAL: begin
          wbe = 1'b1; wbv = pc_q + 32'd4; r_pc = pc_q + jimm;
        end
        OPC_JALR: begin
          wbe = 1'b1; wbv = pc_q + 32'd4; r_pc = (a_q + iimm) & ~32'd1;
        end
        OPC_LOAD: begin
          if (f3 == 3'd0 || f3 == 3'd2 || f3 == 3'd4) begin
            r_pk = (f3 == 3'd0) ? PK_LB : (f3 == 3'd4) ? PK_LBU : PK_LW;
            r_pa = a_q + iimm;
            r_po = '0;
            r.status = ST_AWAIT;
            r.bus_op = r_pk;
            r.bus_address = r_pa;
          end else begin
            r_halt = 1'b1; r.status = ST_ILLEGAL;
          end
        end
        OPC_STORE: begin
          r.bus_address = a_q + simm;
          if (f3 == 3'd0) begin
            r.bus_op = BUS_WRB; r.bus_write_data = {24'd0, b_q[7:0]};
          end else if (f3 == 3'd2) begin
            r.bus_op = BUS_WRW; r.bus_write_data = b_q;
          end else begin
            r_halt = 1'b1; r.status = ST_ILLEGAL;
          end
        end
        OPC_FENCE: begin
          if (f3 != 3'd1) begin r_halt = 1'b1; r.status = ST_ILLEGAL; end
        end
        OPC_OPIMM: begin
          wbe = 1'b1;
          case (f3)
            3'd0: wbv = a_q + iimm;
            3'd1: wbv = a_q << w[24:20];
            3'd3: wbv = {31'd0, a_q < iimm};
            3'd5: wbv = a_q >> w[24:20];
            3'd7: wbv = a_q & iimm;
            default: begin r_halt = 1'b1; r.status = ST_ILLEGAL; end
          endcase
        end
        OPC_BRANCH: begin
          case (f3)
            3'd0: take = (a_q == b_q);
            3'd1: take = (a_q != b_q);
            3'd4: take = ($signed(a_q) < $signed(b_q));
            3'd5: take = ($signed(a_q) >= $signed(b_q));
            3'd6: take = (a_q < b_q);
            3'd7: take = (a_q >= b_q);
            default: begin r_halt = 1'b1; r.status = ST_ILLEGAL; end
          endcase
          if (take) r_pc = pc_q + bimm;
        end
        OPC_OP: begin
          wbe = 1'b1;
          if (!f7[0]) begin
            case (f3)
              3'd0: begin
                if (f7 == 7'h20) wbv = a_q - b_q;
                else if (f7 == 7'h00) wbv = a_q + b_q;
                else begin r_halt = 1'b1; r.status = ST_ILLEGAL; end
              end
              3'd1: wbv = a_q << b_q[4:0];
              3'd3: wbv = {31'd0, a_q < b_q};
              3'd4: wbv = a_q ^ b_q;
              3'd6: wbv = a_q | b_q;
              3'd7: wbv = a_q & b_q;
              default: begin r_halt = 1'b1; r.status = ST_ILLEGAL; end
            endcase
          end else if (f3 != 3'd0 && f3 != 3'd3 && f3 != 3'd4) begin
            r_halt = 1'b1; r.status = ST_ILLEGAL;
          end else if (!md_en_q) begin
            r_halt = 1'b1; r.status = ST_NOEXT;
          end else if (f3 == 3'd0) begin
            wbv = prod[31:0];
          end else if (f3 == 3'd3) begin
            wbv = prod[63:32];
          end else begin
            // Quotient from the iterative divider
            if (dzero_q) wbv = '1;
            else if (dovf_q) wbv = dvnd_q;
            else wbv = dneg_q ? (32'd0 - dq_q) : dq_q;
          end
        end
        OPC_AMO: begin
          if (f3 == 3'd2 && (w[31:27] == 5'd0 || w[31:27] == 5'd8)) begin
            r_pk = (w[31:27] == 5'd0) ? PK_AMOADD : PK_AMOOR;
            r_pa = a_q;
            r_po = b_q;
            r.status = ST_AWAIT;
            r.bus_op = BUS_RDW;
            r.bus_address = a_q;
          end else begin
            r_halt = 1'b1; r.status = ST_ILLEGAL;
          end
        end
        default: begin r_halt = 1'b1; r.status = ST_ILLEGAL; end
      endcase
      if (r.status == ST_AWAIT) begin
        wbe = 1'b0; r_pd = dst;
      end
      // Clear every field of a halting item but its status and the pc
      if (r_halt) begin
        h_st = r.status;
        r = '0; r.next_pc = pc_q; r.status = h_st;
        r_pcw = 1'b0; wbe = 1'b0;
      end else begin
        r.next_pc = r_pc;
      end
    end
  end

  logic [4:0] wb_idx;
  assign wb_idx = it_q.command ? pd_q : dst;

  // Fold the register write into the result
  always_comb begin
    result_o = r;
    if (wbe && wb_idx != 5'd0) begin
      result_o.writeback_index = wb_idx;
      result_o.writeback_value = wbv;
    end
  end

  logic commit;
  assign commit = cmd_i.exec || cmd_i.div_done;

  // Architectural state other than the register file data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; md_en_q <= 1'b1; pk_q <= PK_NONE; pd_q <= '0;
      pa_q <= '0; po_q <= '0; halt_q <= 1'b0; rf_valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_START_PC) pc_q <= cfg_data_i;
        else md_en_q <= cfg_data_i[0];
      end
      if (commit) begin
        if (r_pcw && !r_halt) pc_q <= r_pc;
        if (r_halt) halt_q <= 1'b1;
        pk_q <= r_pk; pa_q <= r_pa; po_q <= r_po; pd_q <= r_pd;
        if (wbe && wb_idx != 5'd0) rf_valid_q[wb_idx] <= 1'b1;
      end
    end
  end

  // Register file write
  always_ff @(posedge clk_i) begin
    if (commit && wbe && wb_idx != 5'd0) rf_q[wb_idx] <= wbv;
  end

  // Latch the item and its operands together
  always_ff @(posedge clk_i) begin
    if (in_take_i) it_q <= in_data_i;
    if (cmd_i.rf_read) begin
      a_q <= rf_valid_q[in_data_i.instruction[19:15]] ?
             rf_q[in_data_i.instruction[19:15]] : '0;
      b_q <= rf_valid_q[in_data_i.instruction[24:20]] ?
             rf_q[in_data_i.instruction[24:20]] : '0;
    end
  end

  // Restoring divider on magnitudes, one quotient bit a cycle
  assign dvnd_mag_bit = dsh_q[31];
  assign dtrial = {drem_q, dvnd_mag_bit} - {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dsh_q   <= a_q[31] ? 32'd0 - a_q : a_q;
      dmag_q  <= b_q[31] ? 32'd0 - b_q : b_q;
      drem_q  <= '0;
      dq_q    <= '0;
      dneg_q  <= a_q[31] ^ b_q[31];
      dzero_q <= (b_q == 32'd0);
      dovf_q  <= (a_q == 32'h8000_0000) && (b_q == 32'hFFFF_FFFF);
      dvnd_q  <= a_q;
    end else if (cmd_i.div_step) begin
      dsh_q <= {dsh_q[30:0], 1'b0};
      if (!dtrial[32]) begin
        drem_q <= dtrial[31:0];
        dq_q <= {dq_q[30:0], 1'b1};
      end else begin
        drem_q <= {drem_q[30:0], dvnd_mag_bit};
        dq_q <= {dq_q[30:0], 1'b0};
      end
    end
  end

endmodule
